// ===== src/bayer_rggb_demosaic_swap_assert.svh =====
// ---------------------------------------------------------------------------
// bayer_rggb_demosaic_swap_assert.svh
// assertion macros shared by the demosaic checker
// ---------------------------------------------------------------------------
`ifndef BAYER_RGGB_DEMOSAIC_SWAP_ASSERT_SVH
`define BAYER_RGGB_DEMOSAIC_SWAP_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define BDMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define BDMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bdms_pkg.sv =====
// ---------------------------------------------------------------------------
// bdms_pkg
// types and codes shared by the bayer demosaic modules
// ---------------------------------------------------------------------------
package bdms_pkg;

  localparam int unsigned PixW = 8;
  localparam int unsigned CfgW = 12;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SWAP_MODE    = 2'd2;

  typedef enum logic [1:0] {
    SWAP_NONE = 2'd0,
    SWAP_RB   = 2'd1,
    SWAP_RG   = 2'd2,
    SWAP_GB   = 2'd3
  } swap_e;

  typedef logic [PixW-1:0] pix_t;

  // 2x2 window, row i on top, column j on the left
  typedef struct packed {
    pix_t p00;
    pix_t p01;
    pix_t p10;
    pix_t p11;
  } win_t;

  typedef struct packed {
    logic i_odd;
    logic j_odd;
  } parity_t;

  typedef struct packed {
    pix_t r;
    pix_t g;
    pix_t b;
  } rgb_t;

endpackage

// ===== src/bdms_ram.sv =====
// ---------------------------------------------------------------------------
// bdms_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module bdms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bdms_window.sv =====
// ---------------------------------------------------------------------------
// bdms_window
// picks r, g, b out of a 2x2 rggb window and applies the channel swap
// ---------------------------------------------------------------------------
module bdms_window
  import bdms_pkg::*;
(
  input  win_t    win_i,
  input  parity_t par_i,
  input  swap_e   swap_i,
  output rgb_t    rgb_o
);

  pix_t r;
  pix_t g;
  pix_t b;
  pix_t g_diag;
  pix_t g_anti;

  // each green site halved before the add, so the sum fits in 8 bits
  assign g_anti = {1'b0, win_i.p01[PixW-1:1]} + {1'b0, win_i.p10[PixW-1:1]};
  assign g_diag = {1'b0, win_i.p00[PixW-1:1]} + {1'b0, win_i.p11[PixW-1:1]};

  always_comb begin
    case ({par_i.i_odd, par_i.j_odd})
      2'b00: begin
        r = win_i.p00; g = g_anti; b = win_i.p11;
      end
      2'b01: begin
        r = win_i.p01; g = g_diag; b = win_i.p10;
      end
      2'b10: begin
        r = win_i.p10; g = g_diag; b = win_i.p01;
      end
      default: begin
        r = win_i.p11; g = g_anti; b = win_i.p00;
      end
    endcase
  end

  always_comb begin
    case (swap_i)
      SWAP_RB: rgb_o = '{r: b, g: g, b: r};
      SWAP_RG: rgb_o = '{r: g, g: r, b: b};
      SWAP_GB: rgb_o = '{r: r, g: b, b: g};
      default: rgb_o = '{r: r, g: g, b: b};
    endcase
  end

endmodule

// ===== src/bayer_rggb_demosaic_swap.sv =====
// ---------------------------------------------------------------------------
// bayer_rggb_demosaic_swap
// streaming 2x2 demosaic of an rggb bayer mosaic with channel swap
// ---------------------------------------------------------------------------
//  channel  dir  signals                                   word
//  in       in   in_valid_i in_ready_o raw_pixel_i         one bayer sample
//  out      out  out_valid_o out_ready_i red_o green_o     one rgb pixel
//                blue_o line_end_o frame_end_o
//  cfg      in   cfg_valid_i cfg_ready_o cfg_index_i       one register write
//                cfg_data_i
//
//  one pixel per clock while in_ready_o is high; the result leaves
//  through a single output register, the line buffer read is prefetched
//  at the next column so the window is complete when the pixel arrives.
//  in_ready_o drops only while a result waits and out_ready_i is low.
//  reset clears counters and control; the line buffer needs no clearing.
//  cfg_ready_o is always high.
// ---------------------------------------------------------------------------
module bayer_rggb_demosaic_swap
  import bdms_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [PixW-1:0]    raw_pixel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PixW-1:0]    red_o,
  output logic [PixW-1:0]    green_o,
  output logic [PixW-1:0]    blue_o,
  output logic               line_end_o,
  output logic               frame_end_o
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT);
  localparam int unsigned CmpWW = (ColW + 1 > CfgW) ? ColW + 1 : CfgW;
  localparam int unsigned CmpHW = (RowW + 1 > CfgW) ? RowW + 1 : CfgW;
  localparam logic [CmpWW-1:0] MaxW = CmpWW'(MAX_WIDTH);
  localparam logic [CmpHW-1:0] MaxH = CmpHW'(MAX_HEIGHT);

  // configuration
  logic [CfgW-1:0] frame_width_q;
  logic [CfgW-1:0] frame_height_q;
  swap_e           swap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CfgW'(2048);
      frame_height_q <= CfgW'(2048);
      swap_q         <= SWAP_NONE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        CFG_SWAP_MODE:    swap_q         <= swap_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // clamped frame size
  logic [CmpWW-1:0] fw_ext;
  logic [CmpHW-1:0] fh_ext;
  logic [CmpWW-1:0] eff_w;
  logic [CmpHW-1:0] eff_h;

  assign fw_ext = CmpWW'(frame_width_q);
  assign fh_ext = CmpHW'(frame_height_q);

  always_comb begin
    if (fw_ext < CmpWW'(2)) begin
      eff_w = CmpWW'(2);
    end else if (fw_ext > MaxW) begin
      eff_w = MaxW;
    end else begin
      eff_w = fw_ext;
    end
    if (fh_ext < CmpHW'(2)) begin
      eff_h = CmpHW'(2);
    end else if (fh_ext > MaxH) begin
      eff_h = MaxH;
    end else begin
      eff_h = fh_ext;
    end
  end

  // position and handshake
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            last_col;
  logic            last_row;
  logic            accept;
  logic            emit;
  logic            out_valid_q;

  assign last_col   = (CmpWW'(col_q) + CmpWW'(1)) >= eff_w;
  assign last_row   = (CmpHW'(row_q) + CmpHW'(1)) >= eff_h;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign emit       = accept && (row_q != '0) && (col_q != '0);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  // line buffer, read ahead at the column of the next word
  pix_t above_q;

  bdms_ram #(
    .WIDTH (PixW),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (raw_pixel_i),
    .raddr_i (col_d),
    .rdata_o (above_q)
  );

  pix_t above_left_q;
  pix_t current_left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q          <= '0;
      row_q          <= '0;
      above_left_q   <= '0;
      current_left_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        above_left_q   <= above_q;
        current_left_q <= raw_pixel_i;
      end
    end
  end

  // window and colour selection
  win_t    win;
  parity_t par;
  rgb_t    rgb;

  assign win = '{p00: above_left_q, p01: above_q, p10: current_left_q, p11: raw_pixel_i};
  // output row and column are one behind the arriving pixel
  assign par = '{i_odd: ~row_q[0], j_odd: ~col_q[0]};

  bdms_window u_window (
    .win_i  (win),
    .par_i  (par),
    .swap_i (swap_q),
    .rgb_o  (rgb)
  );

  // output register
  rgb_t rgb_q;
  logic line_end_q;
  logic frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rgb_q       <= rgb;
      line_end_q  <= last_col;
      frame_end_q <= last_col && last_row;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = rgb_q.r;
  assign green_o     = rgb_q.g;
  assign blue_o      = rgb_q.b;
  assign line_end_o  = line_end_q;
  assign frame_end_o = frame_end_q;

endmodule

// ===== src/bdms_checker.sv =====
// ---------------------------------------------------------------------------
// bdms_checker
// port-level checks on the demosaic, bound to the top level
// ---------------------------------------------------------------------------
`include "bayer_rggb_demosaic_swap_assert.svh"

module bdms_checker
  import bdms_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [PixW-1:0] red_o,
  input logic [PixW-1:0] green_o,
  input logic [PixW-1:0] blue_o,
  input logic            line_end_o,
  input logic            frame_end_o
);

  // a stalled result holds its word
  `BDMS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(red_o) && $stable(green_o) && $stable(blue_o) && $stable(line_end_o) && $stable(frame_end_o), "stalled output word changed")

  // the frame closes on the last pixel of a row
  `BDMS_ASSERT_NOW(a_frame_line, out_valid_o && frame_end_o, line_end_o, "frame_end without line_end")

  // input is never blocked while the output register is free
  `BDMS_ASSERT_NOW(a_in_free, !out_valid_o || out_ready_i, in_ready_o, "input stalled with free output")

  // a fresh result needs an input word on the cycle before
  `BDMS_ASSERT_NEXT(a_no_invent, !in_valid_i || !in_ready_o, !out_valid_o || $past(out_valid_o && !out_ready_i), "result without input word")

endmodule

bind bayer_rggb_demosaic_swap bdms_checker u_bdms_checker (.*);
